### hdl/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// Types and codes shared by the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int unsigned KNOT_W  = 32;
    localparam int unsigned Q30_W   = 31;
    localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;

    // knot format Q15.16; ratios are scale-free, so the datapath never uses it
    localparam int unsigned FRAC_BITS = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_SET   = 2'd1,
        ST_RANGE     = 2'd2,
        ST_ORDER     = 2'd3
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_value;
        logic signed [31:0] xi;
        logic [1:0]         degree;
    } in_item_t;

    typedef struct packed {
        logic [30:0] basis_value;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR_RD,
        S_WR_CHK,
        S_LD_RD,
        S_LD_CAP,
        S_SEED,
        S_TERM,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } fsm_t;

endpackage

### hdl/bbe_ram.sv
// ----------------------------------------------------------------------------
// bbe_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/bbe_div.sv
// ----------------------------------------------------------------------------
// bbe_div
// Q1.30 ratio num/den, clamped to [0, 1]; restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module bbe_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [33:0] num,
    input  logic signed [33:0] den,
    output logic               done,
    output logic [30:0]        quot
);
    import bbe_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [33:0] den_reg, den_next;
    logic [30:0] q_reg, q_next;
    logic        done_reg, done_next;
    logic [34:0] shl;

    assign shl = {rem_reg, 1'b0};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (start) begin
            den_next = den;
            rem_next = num;
            cnt_next = '0;
            if (den <= 0 || num <= 0) begin
                q_next = '0;
                done_next = 1'b1;
            end else if (num >= den) begin
                q_next = ONE_Q30;
                done_next = 1'b1;
            end else begin
                q_next = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            // 30 fraction bits; remainder < den so fits in 34 bits
            if (shl >= {1'b0, den_reg}) begin
                rem_next = 34'(shl - {1'b0, den_reg});
                q_next   = {q_reg[29:0], 1'b1};
            end else begin
                rem_next = shl[33:0];
                q_next   = {q_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

### hdl/bspline_basis_eval_top.sv
// ----------------------------------------------------------------------------
// bspline_basis_eval_top
// Cox-de Boor B-spline basis evaluator over a knot table held in RAM.
// ----------------------------------------------------------------------------
// Sequence: a knot write reads the lower neighbor, checks order, then writes; an error
//   goes straight to the result. An evaluation loads p+2 knots, seeds, then works up to
//   p(p+1) ratio terms on the shared bit-serial divider, skipped when the neighbor basis is zero.
// Throughput: one item at a time; the next is taken the cycle after the result
//   leaves.
// Reset: aresetn (sync, active low) clears control and knot_count; knot RAM kept.
module bspline_basis_eval_top #(
    parameter int KNOT_DEPTH = 64,
    parameter int MAX_DEGREE = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  bbe_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bbe_pkg::out_item_t  m_item
);
    import bbe_pkg::*;

    localparam int AW = $clog2(KNOT_DEPTH);
    localparam int NK = MAX_DEGREE + 2;     // knots held for one evaluation
    localparam int NW = $clog2(NK + 1);

    fsm_t state_reg, state_next;

    logic [6:0]  kc_reg;
    in_item_t    it_reg;
    logic        mv_reg;
    out_item_t   res_reg;

    // knot window, loaded from RAM one entry per cycle
    logic signed [31:0] kw_reg [NK];
    logic [30:0]        n_reg  [NK];
    logic [NW-1:0]      ld_reg;     // load counter
    logic [2:0]         d_reg;      // current degree level
    logic [2:0]         j_reg;      // column within level
    logic               side_reg;   // 0 = left term, 1 = right term
    logic [31:0]        acc_reg;
    logic [30:0]        q_reg;
    logic [61:0]        prod_reg;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;

    bbe_ram #(.WIDTH(KNOT_W), .DEPTH(KNOT_DEPTH)) u_ram (
        .aclk (aclk), .we(ram_we), .addr(ram_addr),
        .wdata(it_reg.knot_value), .rdata(ram_rdata)
    );

    // divider
    logic               div_start, div_done;
    logic signed [33:0] div_num, div_den;
    logic [30:0]        div_q;

    bbe_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
    );

    // effective count, saturated to the table depth
    logic [10:0] cnt_eff;
    assign cnt_eff = (32'(kc_reg) > KNOT_DEPTH) ? 11'(KNOT_DEPTH) : 11'(kc_reg);

    logic [8:0] idx_end;
    assign idx_end = 9'(s_item.knot_index) + 9'(s_item.degree) + 9'd1;

    // term operands (left: x - k[j], k[j+d]-k[j]; right: k[j+d+1]-x, ...)
    logic signed [31:0] ka, kb, kc2, kd;
    always_comb begin
        ka  = kw_reg[3'(j_reg)];
        kb  = kw_reg[3'(j_reg + d_reg)];
        kc2 = kw_reg[3'(j_reg + d_reg + 3'd1)];
        kd  = kw_reg[3'(j_reg + 3'd1)];
        if (!side_reg) begin
            div_num = 34'(it_reg.xi) - 34'(ka);
            div_den = 34'(kb) - 34'(ka);
        end else begin
            div_num = 34'(kc2) - 34'(it_reg.xi);
            div_den = 34'(kc2) - 34'(kd);
        end
    end

    logic [30:0] n_cur;
    assign n_cur = side_reg ? n_reg[3'(j_reg + 3'd1)] : n_reg[3'(j_reg)];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !mv_reg) begin
                    if (!s_item.mode) begin
                        state_next = (32'(s_item.knot_index) >= KNOT_DEPTH) ? S_OUT :
                                     S_WR_RD;
                    end else if (cnt_eff == 11'd0 || 32'(s_item.degree) > MAX_DEGREE
                                 || 11'(idx_end) >= cnt_eff) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_LD_RD;
                    end
                end
            end
            S_WR_RD:  state_next = S_WR_CHK;
            S_WR_CHK: state_next = S_OUT;
            S_LD_RD:  state_next = S_LD_CAP;
            S_LD_CAP: state_next = (ld_reg == NW'(32'(it_reg.degree) + 1)) ? S_SEED : S_LD_CAP;
            S_SEED:   state_next = (it_reg.degree == 2'd0) ? S_OUT : S_TERM;
            S_TERM:   state_next = (n_cur != '0) ? S_DIV : S_ACC;
            S_DIV:    state_next = div_done ? S_MUL : S_DIV;
            S_MUL:    state_next = S_ACC;
            S_ACC: begin
                if (!side_reg) begin
                    state_next = S_TERM;
                end else if (32'(j_reg) + 32'(d_reg) >= 32'(it_reg.degree)) begin
                    state_next = (32'(d_reg) >= 32'(it_reg.degree)) ? S_OUT : S_TERM;
                end else begin
                    state_next = S_TERM;
                end
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs to RAM and divider
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = it_reg.knot_index[AW-1:0];
        div_start = 1'b0;
        case (state_reg)
            S_WR_RD:  ram_addr = AW'(it_reg.knot_index - 6'd1);
            S_WR_CHK: ram_we = !((it_reg.knot_index != '0) &&
                                 ($signed(it_reg.knot_value) < $signed(ram_rdata)));
            // read one ahead: the entry captured in a cycle was addressed the cycle before
            S_LD_RD:  ram_addr = AW'(32'(it_reg.knot_index) + 32'(ld_reg));
            S_LD_CAP: ram_addr = AW'(32'(it_reg.knot_index) + 32'(ld_reg) + 1);
            S_TERM:   div_start = (n_cur != '0);
            default:  ram_addr = it_reg.knot_index[AW-1:0];
        endcase
    end

    logic [30:0] prod_q;
    assign prod_q = prod_reg[60:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kc_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                kc_reg <= cfg_wdata;
            end
            if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end
            if (state_reg == S_OUT) begin
                mv_reg <= 1'b1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                // load only on an accepted item; a waiting result stays put
                if (s_valid && !mv_reg) begin
                    it_reg  <= s_item;
                    ld_reg  <= '0;
                    res_reg.basis_value <= '0;
                    if (!s_item.mode && 32'(s_item.knot_index) >= KNOT_DEPTH) begin
                        res_reg.status <= ST_RANGE;
                    end else if (s_item.mode && cnt_eff == 11'd0) begin
                        res_reg.status <= ST_NOT_SET;
                    end else if (s_item.mode && (32'(s_item.degree) > MAX_DEGREE ||
                                                 11'(idx_end) >= cnt_eff)) begin
                        res_reg.status <= ST_RANGE;
                    end else begin
                        res_reg.status <= ST_OK;
                    end
                end
            end
            S_WR_CHK: begin
                if (!ram_we) begin
                    res_reg.status <= ST_ORDER;
                end
            end
            S_LD_CAP: begin
                kw_reg[ld_reg] <= ram_rdata;
                ld_reg <= ld_reg + NW'(1);
            end
            S_SEED: begin
                for (int k = 0; k < NK - 1; k++) begin
                    n_reg[k] <= (it_reg.xi >= kw_reg[k] && it_reg.xi < kw_reg[k+1]) ?
                                ONE_Q30 : '0;
                end
                n_reg[NK-1] <= '0;
                res_reg.basis_value <= (it_reg.xi >= kw_reg[0] && it_reg.xi < kw_reg[1]) ?
                                       ONE_Q30 : '0;
                d_reg    <= 3'd1;
                j_reg    <= '0;
                side_reg <= 1'b0;
                acc_reg  <= '0;
            end
            S_DIV: begin
                q_reg <= div_q;
            end
            S_MUL: begin
                prod_reg <= q_reg * n_cur;
            end
            S_ACC: begin
                logic [31:0] sum;
                logic [30:0] sat;
                sum = acc_reg + ((n_cur != '0) ? {1'b0, prod_q} : 32'd0);
                sat = (sum > 32'(ONE_Q30)) ? ONE_Q30 : sum[30:0];
                if (!side_reg) begin
                    acc_reg  <= sum;
                    side_reg <= 1'b1;
                end else begin
                    n_reg[3'(j_reg)] <= sat;
                    // column 0 of the last level is the answer
                    if (j_reg == 3'd0) begin
                        res_reg.basis_value <= sat;
                    end
                    side_reg <= 1'b0;
                    acc_reg  <= '0;
                    if (32'(j_reg) + 32'(d_reg) >= 32'(it_reg.degree)) begin
                        j_reg <= '0;
                        d_reg <= d_reg + 3'd1;
                    end else begin
                        j_reg <= j_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_item  = res_reg;
endmodule

### sim/tb_bspline_basis_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bspline_basis_eval_top
// Self-checking bench for the B-spline basis evaluator. It fills the knot
// table in ascending order, then runs directed and random knot writes and
// basis evaluations over several knot_count settings. A scoreboard computes
// each expected result in Q1.30 fixed point and compares it with the result
// stream. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_bspline_basis_eval_top;
    import bbe_pkg::*;

    localparam int     DEPTH     = 64;
    localparam int     MAX_DEG   = 3;
    localparam longint Q30_ONE   = longint'(1) << 30;
    localparam longint KMIN      = -longint'(2147483647) - 1;
    localparam longint KMAX      = 2147483647;
    localparam int     SETTLE    = 700;       // one worst-case evaluation plus margin
    localparam int     LIMIT     = 3_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow knot table, knot_count, and the queue of expected items
    // ------------------------------------------------------------------------
    class basis_scoreboard;
        longint    knots[DEPTH];
        int        count;
        out_item_t pending_q[$];
        int        errors, n_writes, n_evals, n_ok_evals, n_order;

        function longint q30_ratio(longint num, longint den);
            if (den <= 0 || num <= 0) return 0;
            if (num >= den) return Q30_ONE;
            return (num << 30) / den;
        endfunction

        function out_item_t basis_of(in_item_t it);
            out_item_t r;
            longint    n[MAX_DEG+1];
            longint    x, s;
            int        idx, p, cnt, a;
            r.basis_value = '0;
            r.status      = ST_OK;
            idx = it.knot_index;
            if (it.mode == 1'b0) begin
                n_writes++;
                if (idx > 0 && longint'(it.knot_value) < knots[idx-1]) begin
                    r.status = ST_ORDER;
                    n_order++;
                end else begin
                    knots[idx] = it.knot_value;
                end
                return r;
            end
            n_evals++;
            x   = it.xi;
            p   = it.degree;
            cnt = (count > DEPTH) ? DEPTH : count;
            if (cnt == 0) begin
                r.status = ST_NOT_SET;
            end else if (p > MAX_DEG || idx + p + 1 >= cnt) begin
                r.status = ST_RANGE;
            end else begin
                n_ok_evals++;
                for (int j = 0; j <= p; j++)
                    n[j] = (x >= knots[idx+j] && x < knots[idx+j+1]) ? Q30_ONE : 0;
                // Cox-de Boor triangle, each level folds two neighbors
                for (int d = 1; d <= p; d++) begin
                    for (int j = 0; j + d <= p; j++) begin
                        a = idx + j;
                        s = 0;
                        if (n[j] != 0)
                            s += (q30_ratio(x - knots[a], knots[a+d] - knots[a]) * n[j]) >> 30;
                        if (n[j+1] != 0)
                            s += (q30_ratio(knots[a+d+1] - x, knots[a+d+1] - knots[a+1])
                                  * n[j+1]) >> 30;
                        if (s > Q30_ONE) s = Q30_ONE;
                        n[j] = s;
                    end
                end
                r.basis_value = n[0][30:0];
            end
            return r;
        endfunction

        function void note_input(in_item_t it);
            pending_q.push_back(basis_of(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_q.size() == 0) begin
                $error("result item with nothing expected: basis_value=%0d status=%0d",
                       got.basis_value, got.status);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.basis_value !== want.basis_value) begin
                $error("basis_value: expected %0d, got %0d", want.basis_value, got.basis_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    basis_scoreboard sb = new();
    bit          no_idle = 1'b0;      // burst stretch: neither side idles
    int          hold_cycles = 0;     // receiver hold-off request
    int          cycle_cnt = 0;

    always #10 aclk = ~aclk;

    bspline_basis_eval_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: check on handshake, then pick ready for the next edge.
    // A hold-off keeps ready low for a counted stretch so the block backs up.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_item);
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    // Offer one item; valid stays up with a steady payload until taken
    task automatic send_item(in_item_t it);
        while (!no_idle && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic drain_all();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    // Only while idle: results drained and the block given time to settle
    task automatic set_knot_count(int v);
        drain_all();
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[6:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.count = v;
    endtask

    function automatic in_item_t knot_write(int idx, longint v);
        in_item_t it = '0;
        it.mode       = 1'b0;
        it.knot_index = idx[5:0];
        it.knot_value = v[31:0];
        return it;
    endfunction

    function automatic in_item_t basis_eval(int idx, int p, longint x);
        in_item_t it = '0;
        it.mode       = 1'b1;
        it.knot_index = idx[5:0];
        it.degree     = p[1:0];
        it.xi         = x[31:0];
        return it;
    endfunction

    // Random item: mostly evaluations aimed at the support of the basis,
    // some ordered writes, some order violations, some raw noise.
    function automatic in_item_t random_item();
        in_item_t it;
        int       sel, idx, p, cnt;
        longint   v, x;
        sel = $urandom_range(99);
        cnt = (sb.count > DEPTH) ? DEPTH : sb.count;
        if (sel < 8) begin
            it = in_item_t'({$urandom, $urandom, $urandom});
        end else if (sel < 22) begin
            idx = $urandom_range(1, DEPTH - 1);
            if (sel < 18)
                v = sb.knots[idx-1] + $urandom_range(0, 3 * 65536);
            else
                v = sb.knots[idx-1] - 1 - $urandom_range(0, 65536);
            if (v > KMAX) v = KMAX;
            if (v < KMIN) v = KMIN;
            it = knot_write(idx, v);
        end else begin
            p = $urandom_range(0, MAX_DEG);
            if (cnt >= p + 2 && $urandom_range(9) != 0)
                idx = $urandom_range(0, cnt - p - 2);
            else
                idx = $urandom_range(0, DEPTH - 1);
            x = sb.knots[(idx + $urandom_range(0, p + 1)) % DEPTH];
            if ($urandom_range(3) != 0)
                x = x + longint'($urandom_range(0, 4 * 65536)) - 2 * 65536;
            if (x > KMAX) x = KMAX;
            if (x < KMIN) x = KMIN;
            it = basis_eval(idx, p, x);
        end
        return it;
    endfunction

    task automatic random_phase(int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 3) no_idle = 1'b1;       // long stretch, no idling
            if (i == n_items / 3 + 60) no_idle = 1'b0;
            send_item(random_item());
        end
    endtask

    initial begin
        longint kv;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Knot table empty: evaluations report knots not set
        set_knot_count(0);
        send_item(basis_eval(0, 0, 0));
        send_item(basis_eval(63, 3, KMAX));

        // Ascending fill; slot 0 at the minimum, slot 63 at the maximum,
        // slots 20 and 21 equal for a zero-width span
        for (int j = 0; j < DEPTH; j++) begin
            kv = longint'(j - 32) * 65536;
            if (j == 0)  kv = KMIN;
            if (j == 21) kv = longint'(20 - 32) * 65536;
            if (j == 63) kv = KMAX;
            send_item(knot_write(j, kv));
        end
        send_item(knot_write(10, KMIN));                // order violation
        send_item(knot_write(0, KMIN));                 // slot 0 has no lower neighbor

        set_knot_count(64);
        for (int p = 0; p <= MAX_DEG; p++)
            send_item(basis_eval(30, p, longint'(30 - 32) * 65536 + 40000));
        send_item(basis_eval(20, 0, longint'(20 - 32) * 65536));   // equal-knot span
        send_item(basis_eval(19, 2, longint'(20 - 32) * 65536));   // zero denominator
        send_item(basis_eval(0, 3, KMIN));
        send_item(basis_eval(59, 3, KMAX));
        send_item(basis_eval(62, 1, 0));                 // index past the end
        send_item(basis_eval(60, 3, 0));
        send_item(basis_eval(5, 1, longint'(6 - 32) * 65536));  // peak of a hat

        // Receiver stalls long; the sender keeps offering so input backs up
        hold_cycles = 300;
        for (int i = 0; i < 4; i++) send_item(random_item());
        drain_all();                                      // sender pause

        random_phase(300);
        set_knot_count(127);    // saturates to the table depth
        random_phase(300);
        set_knot_count(2);
        random_phase(200);
        set_knot_count(1);
        random_phase(100);
        set_knot_count(37);
        random_phase(300);
        set_knot_count($urandom_range(3, 126));
        random_phase(300);

        drain_all();
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d knot writes (%0d order violations), %0d evaluations",
                 sb.n_writes, sb.n_order, sb.n_evals);
        $display("%0d evaluations in range across knot_count 0,1,2,37,64,127 and random",
                 sb.n_ok_evals);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### sim.f
hdl/bbe_pkg.sv
hdl/bbe_ram.sv
hdl/bbe_div.sv
hdl/bspline_basis_eval_top.sv
sim/tb_bspline_basis_eval_top.sv
